// ===== design/snapshot_history_floor_lookup_core_assert.svh =====
// Assertion macros used by the checker module of the snapshot history core.
`ifndef SNAPSHOT_HISTORY_FLOOR_LOOKUP_CORE_ASSERT_SVH
`define SNAPSHOT_HISTORY_FLOOR_LOOKUP_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SHFL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication, disabled during reset.
`define SHFL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

// ===== design/shfl_pkg.sv =====
// Package with types and constants of the snapshot history floor lookup core.
package shfl_pkg;

   localparam int HISTORY_DEPTH_DEF = 16;

   localparam int TIME_W  = 64;
   localparam int ROOT_W  = 32;
   localparam int CSR_W   = 32;
   localparam int CSR_IDX_W = 2;

   // Request opcodes
   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_FIND   = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LIVE_ROOT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INVALID_PAGE = 2'd1;

   // Status codes
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_INVALID = 1'b1;

   // One history entry as held in the memory
   typedef struct packed {
      logic [TIME_W-1:0] snap_time;
      logic [ROOT_W-1:0] snap_root;
   } snap_entry_type;

endpackage

// ===== design/snapshot_history_floor_lookup_core.sv =====
// Snapshot history ring with floor lookup over an entry memory with one write and one read port.
//
//   channel | ports                                   | transfer when
//   --------+-----------------------------------------+----------------------
//   request | start, busy, req_opcode/timestamp/root  | start && !busy
//   result  | rsp_valid, rsp_found_root/from_history/ | rsp_valid (one cycle)
//           | rsp_status                              |
//   config  | csr_we, csr_index, csr_wdata            | csr_we
//
// A record writes its entry at once and its result shows in the next cycle,
// with busy staying low. A find reads one stored entry per cycle through the
// memory's read port, keeping busy high until its result shows as busy falls.
// Reset clears the fill count, the head pointer and both registers; the memory
// itself is not cleared, only entries below the fill count are read.
// The receiver cannot stall: each result is on the ports for one cycle.
module snapshot_history_floor_lookup_core #(
   parameter int HISTORY_DEPTH = shfl_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_opcode,
   input  logic [shfl_pkg::TIME_W-1:0]     req_timestamp,
   input  logic [shfl_pkg::ROOT_W-1:0]     req_root_id,
   output logic                            rsp_valid,
   output logic [shfl_pkg::ROOT_W-1:0]     rsp_found_root,
   output logic                            rsp_from_history,
   output logic                            rsp_status,
   input  logic                            csr_we,
   input  logic [shfl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [shfl_pkg::CSR_W-1:0]      csr_wdata
);

   localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(HISTORY_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(HISTORY_DEPTH);
   localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(HISTORY_DEPTH);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   // Control state
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   oldest_ff, oldest_in;
   logic [CNT_W-1:0]   issued_ff, issued_in;
   logic [IDX_W-1:0]   scan_slot_ff, scan_slot_in;
   logic               rd_vld_ff, rd_vld_in;
   logic               hit_ff, hit_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Payload state
   logic [shfl_pkg::ROOT_W-1:0] live_root_ff, live_root_in;
   logic [shfl_pkg::ROOT_W-1:0] invalid_page_ff, invalid_page_in;
   logic [shfl_pkg::TIME_W-1:0] query_ff, query_in;
   logic [shfl_pkg::TIME_W-1:0] best_time_ff, best_time_in;
   logic [shfl_pkg::ROOT_W-1:0] best_root_ff, best_root_in;
   logic [shfl_pkg::ROOT_W-1:0] rsp_root_ff, rsp_root_in;
   logic                        rsp_hist_ff, rsp_hist_in;
   logic                        rsp_status_ff, rsp_status_in;

   // Memory
   shfl_pkg::snap_entry_type mem [HISTORY_DEPTH];
   shfl_pkg::snap_entry_type rd_data_ff;
   shfl_pkg::snap_entry_type wr_data;
   logic                     mem_we;
   logic [IDX_W-1:0]         wr_addr;

   logic               accept;
   logic [SUM_W-1:0]   tail_sum;
   logic [IDX_W-1:0]   tail_slot;
   logic               is_full;
   logic               cand_ok;
   logic               cand_better;

   assign accept  = start && (state_ff == ST_IDLE);
   assign is_full = (count_ff == FULL_CNT);

   // Slot after the newest entry; sum stays below twice the depth
   always_comb begin
      tail_sum = SUM_W'(oldest_ff) + SUM_W'(count_ff);
      if (tail_sum >= DEPTH_SUM) begin
         tail_sum = tail_sum - DEPTH_SUM;
      end
      tail_slot = tail_sum[IDX_W-1:0];
   end

   // Candidate test: not after the query, and strictly nearer than the best so
   // far. Before any hit, only the all-ones distance is refused.
   always_comb begin
      cand_ok = (rd_data_ff.snap_time <= query_ff);
      if (hit_ff) begin
         cand_better = (rd_data_ff.snap_time > best_time_ff);
      end else begin
         cand_better = !((rd_data_ff.snap_time == '0) && (&query_ff));
      end
   end

   // Next-state logic
   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      oldest_in       = oldest_ff;
      issued_in       = issued_ff;
      scan_slot_in    = scan_slot_ff;
      rd_vld_in       = 1'b0;
      hit_in          = hit_ff;
      rsp_valid_in    = 1'b0;
      live_root_in    = live_root_ff;
      invalid_page_in = invalid_page_ff;
      query_in        = query_ff;
      best_time_in    = best_time_ff;
      best_root_in    = best_root_ff;
      rsp_root_in     = rsp_root_ff;
      rsp_hist_in     = rsp_hist_ff;
      rsp_status_in   = rsp_status_ff;
      mem_we          = 1'b0;
      wr_addr         = tail_slot;
      wr_data.snap_time = req_timestamp;
      wr_data.snap_root = req_root_id;

      // Register writes
      if (csr_we) begin
         unique case (csr_index)
            shfl_pkg::CSR_LIVE_ROOT:    live_root_in    = csr_wdata;
            shfl_pkg::CSR_INVALID_PAGE: invalid_page_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_opcode == shfl_pkg::OP_RECORD) begin
                  // Append; when full, overwrite the oldest and advance the head
                  mem_we = 1'b1;
                  if (is_full) begin
                     wr_addr   = oldest_ff;
                     oldest_in = (oldest_ff == LAST_SLOT) ? '0 : oldest_ff + 1'b1;
                  end else begin
                     count_in = count_ff + 1'b1;
                  end
                  rsp_valid_in  = 1'b1;
                  rsp_root_in   = '0;
                  rsp_hist_in   = 1'b0;
                  rsp_status_in = shfl_pkg::STATUS_OK;
               end else begin
                  // Start the scan at the oldest entry
                  state_in     = ST_SCAN;
                  query_in     = req_timestamp;
                  best_root_in = live_root_ff;
                  best_time_in = '0;
                  hit_in       = 1'b0;
                  issued_in    = '0;
                  scan_slot_in = oldest_ff;
               end
            end
         end
         ST_SCAN: begin
            // Issue one read a cycle
            if (issued_ff != count_ff) begin
               rd_vld_in    = 1'b1;
               issued_in    = issued_ff + 1'b1;
               scan_slot_in = (scan_slot_ff == LAST_SLOT) ? '0 : scan_slot_ff + 1'b1;
            end
            // Evaluate the entry read last cycle
            if (rd_vld_ff && cand_ok && cand_better) begin
               best_time_in = rd_data_ff.snap_time;
               best_root_in = rd_data_ff.snap_root;
               hit_in       = 1'b1;
            end
            // All entries seen: deliver
            if ((issued_ff == count_ff) && !rd_vld_ff) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_root_in   = best_root_ff;
               rsp_hist_in   = hit_ff;
               rsp_status_in = (best_root_ff == invalid_page_ff) ?
                               shfl_pkg::STATUS_INVALID : shfl_pkg::STATUS_OK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Memory: records write only when idle; the read port samples every cycle and only scans use it
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[scan_slot_ff];
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         count_ff        <= '0;
         oldest_ff       <= '0;
         issued_ff       <= '0;
         scan_slot_ff    <= '0;
         rd_vld_ff       <= 1'b0;
         hit_ff          <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         live_root_ff    <= '0;
         invalid_page_ff <= '0;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         oldest_ff       <= oldest_in;
         issued_ff       <= issued_in;
         scan_slot_ff    <= scan_slot_in;
         rd_vld_ff       <= rd_vld_in;
         hit_ff          <= hit_in;
         rsp_valid_ff    <= rsp_valid_in;
         live_root_ff    <= live_root_in;
         invalid_page_ff <= invalid_page_in;
      end
      query_ff      <= query_in;
      best_time_ff  <= best_time_in;
      best_root_ff  <= best_root_in;
      rsp_root_ff   <= rsp_root_in;
      rsp_hist_ff   <= rsp_hist_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found_root   = rsp_root_ff;
   assign rsp_from_history = rsp_hist_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

// ===== design/shfl_core_checker.sv =====
// Port-level checker for the snapshot history core, bound to the top level.
`include "snapshot_history_floor_lookup_core_assert.svh"

module shfl_core_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_opcode,
   input logic rsp_valid
);

   // A record transfer answers in the very next cycle
   `SHFL_ASSERT_NEXT(a_record_next, clock, reset, start && !busy && (req_opcode == shfl_pkg::OP_RECORD), rsp_valid && !busy)
   // A find transfer holds the block busy with no result yet
   `SHFL_ASSERT_NEXT(a_find_busy, clock, reset, start && !busy && (req_opcode == shfl_pkg::OP_FIND), busy && !rsp_valid)
   // Results never show while a scan runs
   `SHFL_ASSERT_IMPL(a_rsp_idle, clock, reset, rsp_valid, !busy)
   // The end of a scan delivers its result
   `SHFL_ASSERT_IMPL(a_scan_done, clock, reset, $fell(busy) && !$past(reset), rsp_valid)

endmodule

bind snapshot_history_floor_lookup_core shfl_core_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_opcode (req_opcode),
   .rsp_valid  (rsp_valid)
);
